[hw/rtl/assert_macros.svh]
// assertion macros shared by the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, disabled during reset
`define MKCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the following edge, disabled during reset
`define MKCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mkcs_pkg.sv]
// shared constants, types and needle tables of the keyword scanner
`default_nettype none

package mkcs_pkg;

    // window of compared bytes: current byte plus history
    localparam int unsigned WINDOW_BYTES = 28;
    localparam int unsigned HIST_DEPTH   = WINDOW_BYTES - 1;

    // needle sets
    localparam int unsigned SET_NUM      = 2;
    localparam int unsigned SET_SLOTS    = 8;
    localparam int unsigned NEEDLE_COUNT = 8;
    localparam int unsigned NEEDLES_USED =
        (NEEDLE_COUNT < SET_SLOTS) ? NEEDLE_COUNT : SET_SLOTS;

    // configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_PATTERN_SET = 1'b0;

    typedef logic [7:0]                text_byte_t;
    typedef logic [8*WINDOW_BYTES-1:0] window_t;

    // needle text, last character in the low byte, zero padded above
    localparam window_t NEEDLE_TEXT [SET_NUM][SET_SLOTS] = '{
        '{
            window_t'("ignore previous instructions"),
            window_t'("ignore all previous"),
            window_t'("developer message"),
            window_t'("system prompt"),
            window_t'("reveal hidden"),
            window_t'("exfiltrate"),
            window_t'("disable safety"),
            window_t'("bypass policy")
        },
        '{
            window_t'("authorization:"),
            window_t'("api_key"),
            window_t'("secret="),
            window_t'("token="),
            window_t'("password="),
            window_t'("begin private key"),
            window_t'("sk-"),
            window_t'(0)
        }
    };

    // needle lengths in bytes, zero marks an empty slot
    localparam int unsigned NEEDLE_SIZE [SET_NUM][SET_SLOTS] = '{
        '{28, 19, 17, 13, 13, 10, 14, 13},
        '{14,  7,  7,  6,  9, 17,  3,  0}
    };

    // byte mask covering the low len bytes of the window
    function automatic window_t needle_mask(input int unsigned len);
        window_t ones;
        ones = '1;
        return ~(ones << (8 * len));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/multi_keyword_ci_scanner_unit.sv]
// top level of the case-insensitive multi-keyword text scanner
`default_nettype none

// Scans a text one byte per item and reports, on the item that carries
// end_of_text, whether any needle of the selected set (pattern_set: 0 for
// injection phrases, 1 for leak keywords) occurred anywhere in the text.
// Only A-Z are folded to lower case. One byte is taken every cycle while
// in_stall is low: an input register holds the folded byte, and from there
// the needle bank compares it with the 27-byte history in parallel, shifts
// the history or, for the last byte, clears it and loads the result register.
// A result is thus loaded into the result register once its last byte
// leaves the input register. Bytes that are not the last cause no
// result. The input stalls only when a last byte waits for a result
// register that is still held by out_stall.
// pattern_set is written over the APB port at byte address 0.

`include "assert_macros.svh"

module multi_keyword_ci_scanner_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mkcs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mkcs_pkg::PDATA_W-1:0] pwdata,
    output logic      [mkcs_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   text_byte,
    input  wire logic                         end_of_text,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              keyword_found
);

    // lower-case fold of A-Z only
    function automatic mkcs_pkg::text_byte_t fold_byte(input mkcs_pkg::text_byte_t c);
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    logic                        pattern_set_reg;
    logic                        pattern_set_next;
    logic                        cfg_write;
    logic                        cfg_index;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    mkcs_pkg::text_byte_t        s1_byte_reg;
    logic                        s1_eot_reg;
    logic                        s1_go;
    logic                        in_accept;

    mkcs_pkg::text_byte_t        hist_reg [mkcs_pkg::HIST_DEPTH];
    mkcs_pkg::text_byte_t        hist_next [mkcs_pkg::HIST_DEPTH];
    logic                        hit_reg;
    logic                        hit_next;

    mkcs_pkg::window_t           window;
    logic                        any_hit;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_found_reg;
    logic                        out_free;

    // configuration register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[mkcs_pkg::PADDR_W-1];

    always_comb
    begin
        pattern_set_next = pattern_set_reg;
        if (cfg_write && cfg_index == mkcs_pkg::REG_PATTERN_SET)
        begin
            pattern_set_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_index == mkcs_pkg::REG_PATTERN_SET)
        begin
            prdata[0] = pattern_set_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_set_reg <= 1'b0;
        end
        else
        begin
            pattern_set_reg <= pattern_set_next;
        end
    end

    // flow control: a last byte needs a free result register
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_go     = s1_valid_reg && (!s1_eot_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    // input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= fold_byte(text_byte);
            s1_eot_reg  <= end_of_text;
        end
    end

    // window: current byte low, history above it
    always_comb
    begin
        window[7:0] = s1_byte_reg;
        for (int k = 0; k < mkcs_pkg::HIST_DEPTH; k++)
        begin
            window[8*(k+1) +: 8] = hist_reg[k];
        end
    end

    mkcs_needle_bank u_needle_bank (
        .window      (window),
        .pattern_set (pattern_set_reg),
        .any_hit     (any_hit)
    );

    // history shift and sticky hit, cleared after the last byte
    always_comb
    begin
        hist_next = hist_reg;
        hit_next  = hit_reg;
        if (s1_go)
        begin
            if (s1_eot_reg)
            begin
                for (int k = 0; k < mkcs_pkg::HIST_DEPTH; k++)
                begin
                    hist_next[k] = '0;
                end
                hit_next = 1'b0;
            end
            else
            begin
                hist_next[0] = s1_byte_reg;
                for (int k = 1; k < mkcs_pkg::HIST_DEPTH; k++)
                begin
                    hist_next[k] = hist_reg[k-1];
                end
                hit_next = hit_reg || any_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mkcs_pkg::HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
            hit_reg <= 1'b0;
        end
        else
        begin
            hist_reg <= hist_next;
            hit_reg  <= hit_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_eot_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_eot_reg)
        begin
            out_found_reg <= hit_reg || any_hit;
        end
    end

    assign out_valid     = out_valid_reg;
    assign keyword_found = out_found_reg;

    // checks
    `MKCS_ASSERT_SAME(a_stall_only_on_blocked_end,
        in_stall,
        s1_valid_reg && s1_eot_reg && out_valid_reg && out_stall,
        "input stalled without a blocked last item")
    `MKCS_ASSERT_NEXT(a_clear_after_end,
        s1_go && s1_eot_reg,
        !hit_reg && hist_reg[0] == '0,
        "history or hit flag not cleared after the last item")
    `MKCS_ASSERT_NEXT(a_sticky_hit_reported,
        s1_go && s1_eot_reg && hit_reg,
        out_valid_reg && out_found_reg,
        "recorded hit not reported at end of text")

endmodule

`default_nettype wire

[hw/rtl/mkcs_needle_bank.sv]
// parallel compare of the byte window against both needle sets
`default_nettype none

module mkcs_needle_bank (
    input  wire mkcs_pkg::window_t window,
    input  wire logic              pattern_set,
    output logic                   any_hit
);

    logic [mkcs_pkg::SET_NUM-1:0] set_hit;

    // one masked compare per needle, or-reduced per set
    always_comb
    begin
        set_hit = '0;
        for (int s = 0; s < mkcs_pkg::SET_NUM; s++)
        begin
            for (int i = 0; i < mkcs_pkg::NEEDLES_USED; i++)
            begin
                if (mkcs_pkg::NEEDLE_SIZE[s][i] != 0 &&
                    mkcs_pkg::NEEDLE_SIZE[s][i] <= mkcs_pkg::WINDOW_BYTES &&
                    ((window ^ mkcs_pkg::NEEDLE_TEXT[s][i]) &
                     mkcs_pkg::needle_mask(mkcs_pkg::NEEDLE_SIZE[s][i])) == '0)
                begin
                    set_hit[s] = 1'b1;
                end
            end
        end
    end

    // pick the selected set
    assign any_hit = set_hit[pattern_set];

endmodule

`default_nettype wire
